FILE: rtl/core/irfr_pkg.sv
// ============================================================================
// irfr_pkg - shared types and constants of the image fragment reassembler
// Report framing positions and values, queue depths, and the word formats
// that pass between the front end, the operation queue and the back end.
// ============================================================================
package irfr_pkg;

    // Report framing
    localparam logic [8:0] POS_MAX     = 9'd511;
    localparam logic [8:0] HDR_POS     = 9'd0;
    localparam logic [8:0] TAIL_POS    = 9'd49;
    localparam logic [8:0] FRAG_POS    = 9'd52;
    localparam logic [8:0] PAYLOAD_POS = 9'd59;
    localparam logic [7:0] HDR_VAL     = 8'h31;
    localparam logic [7:0] TAIL_VAL    = 8'h03;

    // Register and state reset values
    localparam logic [7:0] LAST_FRAGMENT_RESET = 8'd3;
    localparam logic [7:0] EXPECTED_RESET      = 8'd1;

    // Widths fixed by the word fields
    localparam int ADDR_W = 17;
    localparam int FRAG_W = 8;
    localparam int BYTE_W = 8;

    // Queue depths
    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Modulo unit: one quotient bit per cycle over a 9-bit dividend
    localparam int MOD_W     = 9;
    localparam int MOD_CNT_W = 4;
    localparam logic [MOD_CNT_W-1:0] MOD_STEPS = 4'd9;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RESEND  = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    // One operation handed from the front end to the back end
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic              cmd;
        logic              oob;
        kind_t             kind;
        logic [FRAG_W-1:0] frag;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } op_t;

    // One result word waiting at the output
    typedef struct packed {
        kind_t             kind;
        logic [FRAG_W-1:0] frag;
        logic [BYTE_W-1:0] data;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [FRAG_W-1:0] result;
    } mod_rsp_t;

endpackage

FILE: rtl/core/irfr_mod_unit.sv
// ============================================================================
// irfr_mod_unit - iterative remainder unit
// Restoring division, one bit per cycle, producing dividend mod divisor.
// ============================================================================
module irfr_mod_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  irfr_pkg::mod_req_t req,
    output irfr_pkg::mod_rsp_t rsp
);

    logic [irfr_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [irfr_pkg::MOD_W-1:0]     dvd_reg, dvd_next;
    logic [irfr_pkg::MOD_W-1:0]     dvs_reg, dvs_next;
    logic [irfr_pkg::MOD_W-1:0]     rem_reg, rem_next;
    logic [irfr_pkg::MOD_W:0]       trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        trial    = {rem_reg, dvd_reg[irfr_pkg::MOD_W-1]};
        if (req.start)
        begin
            cnt_next = irfr_pkg::MOD_STEPS;
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            rem_next = trial[irfr_pkg::MOD_W-1:0];
            dvd_next = {dvd_reg[irfr_pkg::MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy   = (cnt_reg != '0);
    assign rsp.done   = (cnt_reg == irfr_pkg::MOD_CNT_W'(1)) && !req.start;
    assign rsp.result = rem_next[irfr_pkg::FRAG_W-1:0];

endmodule

FILE: rtl/core/irfr_front.sv
// ============================================================================
// irfr_front - report parser and classifier
// Tracks the report byte position and header checks, advances the fragment,
// and turns an accepted word into a store, read or command operation where it calls for one.
// ============================================================================
module irfr_front #(
    parameter int FRAGMENT_BYTES = 300,
    parameter int STORE_SIZE     = 76800
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [irfr_pkg::BYTE_W-1:0]   report_byte,
    input  logic                          report_end,
    input  logic [irfr_pkg::ADDR_W-1:0]   read_address,
    input  logic                          cfg_wr_en,
    input  logic [irfr_pkg::FRAG_W-1:0]   cfg_wr_data,
    output logic                          opq_push,
    output irfr_pkg::op_t                 opq_op,
    input  logic                          opq_full,
    output irfr_pkg::mod_req_t            mod_req,
    input  irfr_pkg::mod_rsp_t            mod_rsp
);

    logic [irfr_pkg::FRAG_W-1:0] last_reg, last_next;
    logic [irfr_pkg::FRAG_W-1:0] cur_reg, cur_next;
    logic [irfr_pkg::FRAG_W-1:0] exp_reg, exp_next;
    logic [irfr_pkg::FRAG_W-1:0] rf_reg, rf_next;
    logic [8:0]                  pos_reg, pos_next;
    logic                        hv_reg, hv_next;
    logic                        pa_reg, pa_next;
    logic [irfr_pkg::ADDR_W-1:0] base_reg, base_next;

    logic                        accept;
    logic                        advance;
    logic                        store_hit;
    logic                        frame_ok;
    logic [8:0]                  offset;
    logic [irfr_pkg::ADDR_W-1:0] waddr;

    assign full   = opq_full || mod_rsp.busy;
    assign accept = push && !full;

    assign offset = pos_reg - irfr_pkg::PAYLOAD_POS;
    assign waddr  = base_reg + irfr_pkg::ADDR_W'(offset);

    assign mod_req.start    = cfg_wr_en;
    assign mod_req.dividend = {1'b0, cur_reg} + 9'd1;
    assign mod_req.divisor  = {1'b0, cfg_wr_data} + 9'd1;

    always_comb
    begin
        last_next = last_reg;
        cur_next  = cur_reg;
        exp_next  = exp_reg;
        rf_next   = rf_reg;
        pos_next  = pos_reg;
        hv_next   = hv_reg;
        pa_next   = pa_reg;
        base_next = base_reg;
        advance   = 1'b0;
        store_hit = 1'b0;
        frame_ok  = 1'b0;

        opq_op      = '0;
        opq_op.kind = irfr_pkg::KIND_REQUEST;

        if (cfg_wr_en)
        begin
            last_next = cfg_wr_data;
        end
        if (mod_rsp.done)
        begin
            exp_next = mod_rsp.result;
        end

        if (accept && opcode)
        begin
            opq_op.rd   = 1'b1;
            opq_op.kind = irfr_pkg::KIND_READ;
            opq_op.addr = read_address;
            opq_op.oob  = ({1'b0, read_address} >= 18'(STORE_SIZE));
        end
        else if (accept)
        begin
            if (pos_reg < irfr_pkg::POS_MAX)
            begin
                if (pos_reg == irfr_pkg::HDR_POS)
                begin
                    hv_next = (report_byte == irfr_pkg::HDR_VAL);
                    pa_next = 1'b0;
                end
                if (pos_reg == irfr_pkg::TAIL_POS && report_byte != irfr_pkg::TAIL_VAL)
                begin
                    hv_next = 1'b0;
                end
                if (pos_reg == irfr_pkg::FRAG_POS)
                begin
                    rf_next = report_byte;
                    advance = hv_next && (report_byte == exp_reg);
                end
                if (advance)
                begin
                    // expected fragment always lies below the span here
                    cur_next  = report_byte;
                    pa_next   = 1'b1;
                    exp_next  = (report_byte == last_reg) ? '0 : report_byte + 8'd1;
                    base_next = irfr_pkg::ADDR_W'(report_byte) *
                                irfr_pkg::ADDR_W'(FRAGMENT_BYTES);
                end
                store_hit = pa_next && (pos_reg >= irfr_pkg::PAYLOAD_POS) &&
                            ({1'b0, offset} < 10'(FRAGMENT_BYTES)) &&
                            ({1'b0, waddr} < 18'(STORE_SIZE));
            end

            opq_op.wr   = store_hit;
            opq_op.addr = waddr;
            opq_op.data = report_byte;

            if (report_end)
            begin
                frame_ok   = hv_next && (pos_reg >= irfr_pkg::FRAG_POS);
                opq_op.cmd = 1'b1;
                if (!frame_ok || rf_next == cur_next)
                begin
                    opq_op.kind = irfr_pkg::KIND_REQUEST;
                    opq_op.frag = cur_next;
                end
                else
                begin
                    opq_op.kind = irfr_pkg::KIND_RESEND;
                    opq_op.frag = exp_next;
                end
                pos_next = '0;
                pa_next  = 1'b0;
            end
            else if (pos_reg < irfr_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    assign opq_push = accept && (opq_op.wr || opq_op.rd || opq_op.cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= irfr_pkg::LAST_FRAGMENT_RESET;
            cur_reg  <= '0;
            exp_reg  <= irfr_pkg::EXPECTED_RESET;
            rf_reg   <= '0;
            pos_reg  <= '0;
            hv_reg   <= 1'b1;
            pa_reg   <= 1'b0;
            base_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
            cur_reg  <= cur_next;
            exp_reg  <= exp_next;
            rf_reg   <= rf_next;
            pos_reg  <= pos_next;
            hv_reg   <= hv_next;
            pa_reg   <= pa_next;
            base_reg <= base_next;
        end
    end

endmodule

FILE: rtl/core/irfr_op_queue.sv
// ============================================================================
// irfr_op_queue - short operation queue between front and back end
// Small register FIFO; the head word is presented while not empty.
// ============================================================================
module irfr_op_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  irfr_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output irfr_pkg::op_t head_op
);

    irfr_pkg::op_t                  slot_reg [irfr_pkg::OPQ_DEPTH];
    logic [irfr_pkg::OPQ_PTR_W-1:0] head_reg, head_next;
    logic [irfr_pkg::OPQ_PTR_W-1:0] tail_reg, tail_next;
    logic [irfr_pkg::OPQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (cnt_reg == irfr_pkg::OPQ_CNT_W'(irfr_pkg::OPQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = slot_reg[head_reg];

    always_comb
    begin
        head_next = do_pop  ? head_reg + 1'b1 : head_reg;
        tail_next = do_push ? tail_reg + 1'b1 : tail_reg;
        cnt_next  = cnt_reg + irfr_pkg::OPQ_CNT_W'(do_push) - irfr_pkg::OPQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/core/irfr_back.sv
// ============================================================================
// irfr_back - image store and result path
// Executes store and read operations on the image memory and queues
// command and read-data words for the output.
// ============================================================================
module irfr_back #(
    parameter int STORE_SIZE = 76800
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        opq_empty,
    input  irfr_pkg::op_t               opq_head,
    output logic                        opq_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  result_kind,
    output logic [irfr_pkg::FRAG_W-1:0] command_fragment,
    output logic [irfr_pkg::BYTE_W-1:0] image_byte
);

    localparam int MEM_AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    logic [irfr_pkg::BYTE_W-1:0] mem [STORE_SIZE];
    logic [irfr_pkg::BYTE_W-1:0] rd_data_reg;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_rd_reg;
    logic                        s1_oob_reg;
    irfr_pkg::kind_t             s1_kind_reg;
    logic [irfr_pkg::FRAG_W-1:0] s1_frag_reg;

    irfr_pkg::res_t                  outq_reg [irfr_pkg::OUTQ_DEPTH];
    logic [irfr_pkg::OUTQ_PTR_W-1:0] oq_head_reg, oq_head_next;
    logic [irfr_pkg::OUTQ_PTR_W-1:0] oq_tail_reg, oq_tail_next;
    logic [irfr_pkg::OUTQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;

    logic                            needs_slot;
    logic                            room;
    logic                            issue;
    logic                            oq_pop;
    irfr_pkg::res_t                  res_word;

    // reserve an output slot for every word still in flight
    assign needs_slot = opq_head.rd || opq_head.cmd;
    assign room       = ({1'b0, oq_cnt_reg} + {{irfr_pkg::OUTQ_CNT_W{1'b0}}, s1_valid_reg})
                        < (irfr_pkg::OUTQ_CNT_W + 1)'(irfr_pkg::OUTQ_DEPTH);
    assign issue      = !opq_empty && (!needs_slot || room);
    assign opq_pop    = issue;

    assign s1_valid_next = issue && needs_slot;

    always_ff @(posedge clk)
    begin
        if (issue && opq_head.wr)
        begin
            mem[opq_head.addr[MEM_AW-1:0]] <= opq_head.data;
        end
        if (issue && opq_head.rd && !opq_head.oob)
        begin
            rd_data_reg <= mem[opq_head.addr[MEM_AW-1:0]];
        end
        s1_rd_reg   <= opq_head.rd;
        s1_oob_reg  <= opq_head.oob;
        s1_kind_reg <= opq_head.kind;
        s1_frag_reg <= opq_head.rd ? '0 : opq_head.frag;
    end

    always_comb
    begin
        res_word.kind = s1_kind_reg;
        res_word.frag = s1_frag_reg;
        res_word.data = (s1_rd_reg && !s1_oob_reg) ? rd_data_reg : '0;
    end

    assign empty  = (oq_cnt_reg == '0);
    assign oq_pop = pop && !empty;

    always_comb
    begin
        oq_head_next = oq_pop       ? oq_head_reg + 1'b1 : oq_head_reg;
        oq_tail_next = s1_valid_reg ? oq_tail_reg + 1'b1 : oq_tail_reg;
        oq_cnt_next  = oq_cnt_reg + irfr_pkg::OUTQ_CNT_W'(s1_valid_reg)
                       - irfr_pkg::OUTQ_CNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            oq_head_reg  <= oq_head_next;
            oq_tail_reg  <= oq_tail_next;
            oq_cnt_reg   <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            outq_reg[oq_tail_reg] <= res_word;
        end
    end

    assign result_kind      = outq_reg[oq_head_reg].kind;
    assign command_fragment = outq_reg[oq_head_reg].frag;
    assign image_byte       = outq_reg[oq_head_reg].data;

    // in-flight word plus queued words never exceed the output queue
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, oq_cnt_reg} + {{irfr_pkg::OUTQ_CNT_W{1'b0}}, s1_valid_reg})
            <= (irfr_pkg::OUTQ_CNT_W + 1)'(irfr_pkg::OUTQ_DEPTH))
        else $error("output queue overcommitted");

    // an in-flight result word lands in the queue on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !oq_pop) |=> (oq_cnt_reg == $past(oq_cnt_reg) + 1'b1))
        else $error("issued result did not reach output queue");

    // store operations never also read and are never out of range
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && opq_head.wr) |-> (!opq_head.rd && !opq_head.oob))
        else $error("malformed store operation");

endmodule

FILE: rtl/core/ir_image_fragment_reassembler.sv
// ============================================================================
// ir_image_fragment_reassembler - camera image fragment reassembler
// Parses camera reports byte by byte, stores in-order fragments into the
// image memory, emits request/resend commands and serves image reads.
// ============================================================================
// Path: a result word goes through the front end, the operation queue, the back
//   end issue with memory read and the output queue.
// Throughput: one input word per cycle while full is low; one result word popped per cycle.
// A last_fragment_index write recomputes the expected fragment in a
//   remainder unit, holding full high while that unit is busy.
// Reset: asynchronous, clears all control state; the image memory is not
//   cleared and has no clearing pass.
module ir_image_fragment_reassembler #(
    parameter int FRAGMENT_BYTES = 300,
    parameter int MAX_FRAGMENTS  = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input word channel
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [7:0]  report_byte,
    input  logic        report_end,
    input  logic [16:0] read_address,
    // result word channel
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [7:0]  command_fragment,
    output logic [7:0]  image_byte,
    // last_fragment_index register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    // Image memory size in bytes; one fragment slot per possible fragment.
    localparam int STORE_SIZE = FRAGMENT_BYTES * MAX_FRAGMENTS;

    irfr_pkg::op_t      front_op;
    logic               front_push;
    logic               opq_full;
    logic               opq_empty;
    logic               opq_pop;
    irfr_pkg::op_t      opq_head;
    irfr_pkg::mod_req_t mod_req;
    irfr_pkg::mod_rsp_t mod_rsp;

    // Expected-fragment remainder after a register write: the span is
    // last_fragment_index + 1, so this is a real modulo by a signal.
    irfr_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Front end: all report state lives here so a new byte can follow
    // the previous one in the next cycle.
    irfr_front #(
        .FRAGMENT_BYTES (FRAGMENT_BYTES),
        .STORE_SIZE     (STORE_SIZE)
    ) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .report_byte  (report_byte),
        .report_end   (report_end),
        .read_address (read_address),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .opq_push     (front_push),
        .opq_op       (front_op),
        .opq_full     (opq_full),
        .mod_req      (mod_req),
        .mod_rsp      (mod_rsp)
    );

    // Decouple parsing from memory and output back-pressure.
    irfr_op_queue u_opq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .push_op (front_op),
        .full    (opq_full),
        .pop     (opq_pop),
        .empty   (opq_empty),
        .head_op (opq_head)
    );

    // Back end: stores and reads execute in queue order, so a read after a
    // store to the same address sees the new byte.
    irfr_back #(
        .STORE_SIZE (STORE_SIZE)
    ) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .opq_empty        (opq_empty),
        .opq_head         (opq_head),
        .opq_pop          (opq_pop),
        .empty            (empty),
        .pop              (pop),
        .result_kind      (result_kind),
        .command_fragment (command_fragment),
        .image_byte       (image_byte)
    );

endmodule

FILE: test/tb_ir_image_fragment_reassembler.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ir_image_fragment_reassembler - self-checking bench for the reassembler
// Streams camera reports and image reads through the input queue and mirrors
// the report parser, fragment tracking and image memory. Compares every result
// word with the mirror field by field, with random idling on both sides and
// several last_fragment_index settings.
// ============================================================================
module tb_ir_image_fragment_reassembler;

    import irfr_pkg::*;

    localparam int FRAG_BYTES     = 300;
    localparam int STORE_SIZE     = FRAG_BYTES * 256;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_WORDS    = 20;    // random words per phase, whole reports
    localparam int SETTLE_CYCLES  = 8;     // drain margin after the last owed reply
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 40;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // How the fragment number of a report is chosen
    typedef enum { FR_NEXT, FR_SAME, FR_AHEAD, FR_RAND } frag_pick_t;

    // One input word as it goes onto the ports
    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        last;
        logic [16:0] addr;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        opcode = OP_BYTE;
    logic [7:0]  report_byte = '0;
    logic        report_end = 1'b0;
    logic [16:0] read_address = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  command_fragment;
    logic [7:0]  image_byte;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    ir_image_fragment_reassembler u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .opcode           (opcode),
        .report_byte      (report_byte),
        .report_end       (report_end),
        .read_address     (read_address),
        .empty            (empty),
        .pop              (pop),
        .result_kind      (result_kind),
        .command_fragment (command_fragment),
        .image_byte       (image_byte),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mirror of the parser state, the register and the image memory
    // ------------------------------------------------------------------------
    logic [7:0] last_idx  = LAST_FRAGMENT_RESET;
    logic [7:0] cur_frag  = '0;
    logic [8:0] pos_q     = '0;
    logic       hdr_ok    = 1'b1;
    logic [7:0] rx_frag   = '0;
    logic       pay_on    = 1'b0;
    logic [7:0] image_mirror [0:STORE_SIZE-1];
    bit         image_known  [0:STORE_SIZE-1];
    int         known_addrs[$];       // addresses that hold a stored byte

    res_t       reply_q[$];           // commands and read bytes still owed
    word_t      word_q[$];            // words waiting for the driver
    int         fed_count  = 0;
    int         mismatches = 0;
    bit         idle_on    = 1'b1;

    // Fragment that would be accepted next under the current register value
    function automatic logic [7:0] next_frag();
        int span;
        span = int'(last_idx) + 1;
        return 8'((int'(cur_frag) + 1) % span);
    endfunction

    // Advance the mirror by one accepted word and queue the reply it causes
    task automatic absorb_word(word_t w);
        int   p;
        int   a;
        res_t r;
        p = int'(pos_q);
        if (w.op == OP_READ)
        begin
            r.kind = KIND_READ;
            r.frag = '0;
            r.data = (int'(w.addr) < STORE_SIZE) ? image_mirror[w.addr] : 8'd0;
            reply_q.push_back(r);
            return;
        end
        // bytes at the saturated position leave the state alone
        if (p < int'(POS_MAX))
        begin
            if (p == int'(HDR_POS))
            begin
                hdr_ok = (w.data == HDR_VAL);
                pay_on = 1'b0;
            end
            if (p == int'(TAIL_POS) && w.data != TAIL_VAL)
                hdr_ok = 1'b0;
            if (p == int'(FRAG_POS))
            begin
                rx_frag = w.data;
                if (hdr_ok && w.data == next_frag())
                begin
                    cur_frag = w.data;
                    pay_on   = 1'b1;
                end
            end
            if (pay_on && p >= int'(PAYLOAD_POS) && p - int'(PAYLOAD_POS) < FRAG_BYTES)
            begin
                a = int'(cur_frag) * FRAG_BYTES + (p - int'(PAYLOAD_POS));
                if (a < STORE_SIZE)
                begin
                    image_mirror[a] = w.data;
                    if (!image_known[a])
                    begin
                        image_known[a] = 1'b1;
                        known_addrs.push_back(a);
                    end
                end
            end
        end
        if (!w.last)
        begin
            pos_q = (p < int'(POS_MAX)) ? 9'(p + 1) : POS_MAX;
            return;
        end
        // end of report: request the current fragment on an invalid report,
        // a match or a repeat; otherwise ask for the expected one again
        r.data = '0;
        if (!(hdr_ok && p >= int'(FRAG_POS)) || rx_frag == cur_frag)
        begin
            r.kind = KIND_REQUEST;
            r.frag = cur_frag;
        end
        else
        begin
            r.kind = KIND_RESEND;
            r.frag = next_frag();
        end
        reply_q.push_back(r);
        pos_q  = '0;
        pay_on = 1'b0;
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH @%0t: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued words, hold while full, idle in random bursts
    // ------------------------------------------------------------------------
    word_t drv_w;
    int    push_gap = 0;

    always @(posedge clk)
    begin : driver
        bit handing;
        handing = 1'b0;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            // take the word on the ports before choosing the next one
            if (push && !full)
                absorb_word(drv_w);
            if (!push || !full)
            begin
                if (push_gap > 0)
                    push_gap--;
                else if (word_q.size() > 0)
                begin
                    drv_w   = word_q.pop_front();
                    handing = 1'b1;
                    if (idle_on && $urandom_range(0, 11) == 0)
                        push_gap = $urandom_range(1, 15);
                end
                if (handing)
                begin
                    push         <= 1'b1;
                    opcode       <= drv_w.op;
                    report_byte  <= drv_w.data;
                    report_end   <= drv_w.last;
                    read_address <= drv_w.addr;
                end
                else
                begin
                    // drop push and scramble the payload while idle
                    push         <= 1'b0;
                    opcode       <= 1'($urandom);
                    report_byte  <= 8'($urandom);
                    report_end   <= 1'($urandom);
                    read_address <= 17'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each popped word against the oldest owed reply
    // ------------------------------------------------------------------------
    int pop_gap = 0;

    always @(posedge clk)
    begin : monitor
        res_t r;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (reply_q.size() == 0)
                    flag_mismatch("result word with nothing owed, kind", result_kind, -1);
                else
                begin
                    r = reply_q.pop_front();
                    if (result_kind !== r.kind)
                        flag_mismatch("result_kind", result_kind, r.kind);
                    if (command_fragment !== r.frag)
                        flag_mismatch("command_fragment", command_fragment, r.frag);
                    if (image_byte !== r.data)
                        flag_mismatch("image_byte", image_byte, r.data);
                end
            end
            // stall the result side in bursts as well
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    pop_gap = $urandom_range(1, 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either side for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_ir_image_fragment_reassembler failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Hand one word to the driver; the short queue keeps the mirror close
    // behind, so fragment numbers and read addresses are chosen from live state
    task automatic feed(word_t w);
        do
            @(negedge clk);
        while (word_q.size() >= 3);
        word_q.push_back(w);
        fed_count++;
    endtask

    task automatic send_read_at(logic [16:0] addr);
        word_t w;
        w.op   = OP_READ;
        w.data = 8'($urandom);
        w.last = 1'($urandom);
        w.addr = addr;
        feed(w);
    endtask

    // Read a stored byte most of the time, else an address past the store;
    // never an in-range entry that was not written
    task automatic send_read();
        logic [16:0] a;
        if (known_addrs.size() > 0 && $urandom_range(0, 3) != 0)
            a = 17'(known_addrs[$urandom_range(0, known_addrs.size() - 1)]);
        else
            a = 17'($urandom_range(STORE_SIZE, 17'h1FFFF));
        send_read_at(a);
    endtask

    function automatic logic [7:0] pick_frag(frag_pick_t pick);
        case (pick)
            FR_NEXT:  return next_frag();
            FR_SAME:  return cur_frag;
            FR_AHEAD: return next_frag() + 8'd1;
            default:  return 8'($urandom);
        endcase
    endfunction

    // Short reports, some carrying the first few payload bytes
    function automatic int pick_len();
        return $urandom_range(53, 64);
    endfunction

    // One report of len bytes; reads slip in between its bytes at read_pct %
    task automatic send_report(logic [7:0] hdr, logic [7:0] tail, frag_pick_t pick,
                               int len, int read_pct);
        word_t w;
        for (int p = 0; p < len; p++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_read();
            w.op   = OP_BYTE;
            w.last = (p == len - 1);
            w.addr = 17'($urandom);
            if (p == int'(HDR_POS))
                w.data = hdr;
            else if (p == int'(TAIL_POS))
                w.data = tail;
            else if (p == int'(FRAG_POS))
                w.data = pick_frag(pick);   // mirror is current at this point
            else
                w.data = 8'($urandom);
            feed(w);
        end
    endtask

    task automatic random_case();
        int         r;
        logic [7:0] junk;
        r    = $urandom_range(0, 99);
        junk = 8'($urandom);
        if (r < 15)
            send_read();
        else if (r < 65)
            send_report(HDR_VAL, TAIL_VAL, FR_NEXT, pick_len(), 6);
        else if (r < 73)
            send_report(HDR_VAL, TAIL_VAL, FR_SAME, pick_len(), 6);
        else if (r < 80)
            send_report(HDR_VAL, TAIL_VAL, FR_AHEAD, pick_len(), 6);
        else if (r < 86)
            send_report(HDR_VAL, TAIL_VAL, FR_RAND, pick_len(), 6);
        else if (r < 91)
        begin
            if (junk == HDR_VAL)
                junk = ~junk;
            send_report(junk, TAIL_VAL, FR_NEXT, pick_len(), 6);
        end
        else if (r < 96)
        begin
            if (junk == TAIL_VAL)
                junk = ~junk;
            send_report(HDR_VAL, junk, FR_NEXT, pick_len(), 6);
        end
        else
            send_report(HDR_VAL, TAIL_VAL, FR_NEXT, $urandom_range(1, 52), 6);
    endtask

    // Directed opening with the reset register value of 3 (fragments 0..3)
    task automatic run_directed();
        send_read_at(17'(STORE_SIZE));                          // past the store
        send_read_at(17'h1FFFF);
        send_report(HDR_VAL, TAIL_VAL, FR_NEXT, 1, 0);          // one-byte report
        send_report(HDR_VAL, TAIL_VAL, FR_NEXT, 52, 0);         // ends before frag
        send_report(HDR_VAL, 8'hFF, FR_NEXT, 53, 0);            // bad tail
        send_report(HDR_VAL, TAIL_VAL, FR_NEXT, 513, 0);        // full fragment 1,
                                                                // then saturate
        send_report(HDR_VAL, TAIL_VAL, FR_AHEAD, 53, 0);        // skip: resend
        repeat (4)
            send_read();
    endtask

    // Wait until every owed reply has come, then let the pipeline drain
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (word_q.size() != 0 || push || reply_q.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Write the register while the block is idle; it holds full while the
    // expected fragment is recomputed, which the driver simply waits out
    task automatic write_last_index(logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        last_idx = v;
    endtask

    initial
    begin : stimulus
        int         start;
        logic [7:0] v;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // first phase runs on the reset value; later ones sweep the range
            if (ph > 0)
            begin
                case (ph)
                    1:       v = 8'd0;
                    2:       v = 8'd255;
                    3:       v = 8'd1;
                    4:       v = 8'($urandom_range(4, 40));
                    default: v = 8'd2;
                endcase
                write_last_index(v);
            end
            // one phase without idling in the middle, none in the last one
            idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
            if (ph == 0)
                run_directed();
            else
            begin
                start = fed_count;
                while (fed_count - start < PHASE_WORDS)
                    random_case();
            end
            wait_quiet();
        end

        if (mismatches == 0)
            $display("tb_ir_image_fragment_reassembler passed");
        else
            $display("tb_ir_image_fragment_reassembler failed");
        $finish;
    end

endmodule
